// ----- hw/rtl/sqwv_pkg.sv -----
// ----------------------------------------------------------------------------
// sqwv_pkg: shared types and constants of the square-wave sound channel
// Operation codes, register indexes, channel state and the duty patterns.
// ----------------------------------------------------------------------------
package sqwv_pkg;

  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned CyclesW   = 8;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned FreqW     = 11;
  localparam int unsigned PeriodW   = 14;
  localparam int unsigned LengthW   = 7;

  localparam logic [PeriodW-1:0] AccumMax   = 14'h3FFF;
  localparam logic [FreqW:0]     FreqSpan   = 12'd2048;
  localparam logic [LengthW-1:0] LengthFull = 7'd64;
  localparam logic [3:0]         VolumeMax  = 4'd15;

  typedef enum logic [FuncW-1:0] {
    FuncTrigger = 2'd0,
    FuncAdvance = 2'd1,
    FuncLength  = 2'd2,
    FuncEnvelope = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrequency  = 3'd0,
    CfgDutySelect = 3'd1,
    CfgInitVolume = 3'd2,
    CfgEnvUp      = 3'd3,
    CfgEnvPeriod  = 3'd4,
    CfgLengthLoad = 3'd5,
    CfgLengthEn   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [FreqW-1:0] frequency;
    logic [1:0]       duty_select;
    logic [3:0]       initial_volume;
    logic             envelope_up;
    logic [2:0]       envelope_period;
    logic [5:0]       length_load;
    logic             length_enable;
  } sqwv_cfg_t;

  typedef struct packed {
    logic [2:0]         duty_step;
    logic [PeriodW-1:0] cycle_accum;
    logic [PeriodW-1:0] step_period;
    logic [LengthW-1:0] length_rem;
    logic [2:0]         env_rem;
    logic [3:0]         volume;
    logic               sounding;
    logic               env_dir;
    logic [2:0]         env_period;
  } sqwv_state_t;

  // Duty patterns, step 0 in the most significant bit.
  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    unique case (sel)
      2'd0:    pat = 8'h01;
      2'd1:    pat = 8'h81;
      2'd2:    pat = 8'h87;
      default: pat = 8'h7E;
    endcase
    return pat;
  endfunction

  function automatic logic [PeriodW-1:0] period_of(input logic [FreqW-1:0] freq);
    logic [FreqW:0] span;
    span = FreqSpan - {1'b0, freq};
    return {span, 2'b00};
  endfunction

endpackage

// ----- hw/rtl/sqwv_next.sv -----
// ----------------------------------------------------------------------------
// sqwv_next: next-state logic of the square-wave channel
// Apply one operation to the channel state and form the sample it produces.
// ----------------------------------------------------------------------------
module sqwv_next (
  input  sqwv_pkg::sqwv_state_t        state_i,
  input  sqwv_pkg::sqwv_cfg_t          cfg_i,
  input  logic [sqwv_pkg::FuncW-1:0]   func_i,
  input  logic [sqwv_pkg::CyclesW-1:0] num_cycles_i,
  output sqwv_pkg::sqwv_state_t        state_o,
  output logic [sqwv_pkg::LevelW-1:0]  sample_level_o,
  output logic                         channel_on_o
);
  import sqwv_pkg::*;

  logic [PeriodW:0]   accum_sum;
  logic [PeriodW-1:0] accum_sat;
  logic [2:0]         env_dec;
  logic [7:0]         pattern;
  logic               duty_bit;

  always_comb begin
    accum_sum = {1'b0, state_i.cycle_accum} + {{(PeriodW+1-CyclesW){1'b0}}, num_cycles_i};
    accum_sat = accum_sum[PeriodW] ? AccumMax : accum_sum[PeriodW-1:0];
    env_dec   = state_i.env_rem - 3'd1;
    state_o   = state_i;

    unique case (func_e'(func_i))
      FuncTrigger: begin
        state_o.duty_step   = '0;
        state_o.length_rem  = LengthFull - {1'b0, cfg_i.length_load};
        state_o.step_period = period_of(cfg_i.frequency);
        state_o.cycle_accum = '0;
        state_o.volume      = cfg_i.initial_volume;
        state_o.env_dir     = cfg_i.envelope_up;
        state_o.env_period  = cfg_i.envelope_period;
        if (cfg_i.envelope_period != 3'd0) begin
          state_o.env_rem = cfg_i.envelope_period;
        end
        state_o.sounding    = 1'b1;
      end
      FuncAdvance: begin
        // at most one duty step per item; the remainder carries over
        if (accum_sat >= state_i.step_period) begin
          state_o.cycle_accum = accum_sat - state_i.step_period;
          state_o.step_period = period_of(cfg_i.frequency);
          state_o.duty_step   = state_i.duty_step + 3'd1;
        end else begin
          state_o.cycle_accum = accum_sat;
        end
      end
      FuncLength: begin
        if (state_i.length_rem != '0) begin
          state_o.length_rem = state_i.length_rem - 7'd1;
          if (state_i.length_rem == 7'd1 && cfg_i.length_enable) begin
            state_o.sounding = 1'b0;
          end
        end
      end
      FuncEnvelope: begin
        if (state_i.env_period != 3'd0) begin
          state_o.env_rem = env_dec;
          if (env_dec == 3'd0) begin
            state_o.env_rem = state_i.env_period;
            if (!state_i.env_dir && state_i.volume != 4'd0) begin
              state_o.volume = state_i.volume - 4'd1;
            end else if (state_i.env_dir && state_i.volume != VolumeMax) begin
              state_o.volume = state_i.volume + 4'd1;
            end
          end
        end
      end
      default: ;
    endcase

    pattern        = duty_pattern(cfg_i.duty_select);
    duty_bit       = pattern[3'd7 - state_o.duty_step];
    sample_level_o = (state_o.sounding && duty_bit) ? state_o.volume : '0;
    channel_on_o   = state_o.sounding;
  end

endmodule

// ----- hw/rtl/square_wave_sound_channel_core.sv -----
// ----------------------------------------------------------------------------
// square_wave_sound_channel_core: square-wave sound channel without sweep
// Trigger, advance, length tick and envelope tick operations, one sample out
// for every operation item.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid_i/in_ready_o | func_i, num_cycles_i
//  out     | out_valid_o/out_ready_i | sample_level_o, channel_on_o
//  cfg     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
//  Each item passes from acceptance into the input register, then through the
//  next-state logic into the result register. One item per clock is sustained
//  while the result side keeps taking samples, set by the single update path.
//  Reset clears all channel state (channel off), the configuration registers and both valid flags; no sweep.
//  A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
module square_wave_sound_channel_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sqwv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sqwv_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sqwv_pkg::FuncW-1:0]     func_i,
  input  logic [sqwv_pkg::CyclesW-1:0]   num_cycles_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sqwv_pkg::LevelW-1:0]    sample_level_o,
  output logic                           channel_on_o
);
  import sqwv_pkg::*;

  sqwv_cfg_t          cfg_q;
  sqwv_state_t        state_q, state_d;
  logic               in_valid_q;
  logic [FuncW-1:0]   func_q;
  logic [CyclesW-1:0] cycles_q;
  logic               out_valid_q;
  logic [LevelW-1:0]  level_q, level_d;
  logic               on_q, on_d;
  logic               advance;

  // Move the held item on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration registers: ignore indexes beyond the list, mask to width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFrequency:  cfg_q.frequency       <= cfg_data_i;
        CfgDutySelect: cfg_q.duty_select     <= cfg_data_i[1:0];
        CfgInitVolume: cfg_q.initial_volume  <= cfg_data_i[3:0];
        CfgEnvUp:      cfg_q.envelope_up     <= cfg_data_i[0];
        CfgEnvPeriod:  cfg_q.envelope_period <= cfg_data_i[2:0];
        CfgLengthLoad: cfg_q.length_load     <= cfg_data_i[5:0];
        CfgLengthEn:   cfg_q.length_enable   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register: hold the item until it moves to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q   <= func_i;
      cycles_q <= num_cycles_i;
    end
  end

  sqwv_next u_next (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .func_i         (func_q),
    .num_cycles_i   (cycles_q),
    .state_o        (state_d),
    .sample_level_o (level_d),
    .channel_on_o   (on_d)
  );

  // Channel state advances only as an item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: hold while stalled, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q <= level_d;
      on_q    <= on_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_level_o = level_q;
  assign channel_on_o   = on_q;

endmodule

// ----- hw/rtl/sqwv_checker.sv -----
// ----------------------------------------------------------------------------
// sqwv_checker: port-level checks of the square-wave channel
// Watch the handshakes and result items of the top level over time.
// ----------------------------------------------------------------------------
module sqwv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sqwv_pkg::LevelW-1:0]   sample_level_o,
  input logic                          channel_on_o
);
  import sqwv_pkg::*;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_level_o)
      && $stable(channel_on_o))
    else $error("result item changed while stalled");

  // A silent channel gives a zero sample.
  a_off_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !channel_on_o |-> sample_level_o == '0)
    else $error("non-zero sample while channel off");

  // Input back-pressure only comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // A result appears only for an item taken at the input, after it has passed the input register.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result item without an accepted input item");

endmodule

bind square_wave_sound_channel_core sqwv_checker u_sqwv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_level_o (sample_level_o),
  .channel_on_o   (channel_on_o)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for square_wave_sound_channel_core
// Drives trigger, advance, length and envelope items through the valid/ready
// input, predicts every sample from a behavioural copy of the channel and
// checks each sample in order, while both sides idle and stall at random and
// the registers change between phases.
// ----------------------------------------------------------------------------

// Behavioural channel plus the queue of samples still owed by the block.
class sample_scoreboard;
  typedef struct packed {
    logic [3:0] level;
    logic       on;
  } sample_t;

  // Register copies
  logic [10:0] freq;
  logic [1:0]  duty_sel;
  logic [3:0]  start_vol;
  logic        env_up;
  logic [2:0]  env_per;
  logic [5:0]  len_load;
  logic        len_en;

  // Channel state
  logic [2:0]  duty_step;
  int unsigned accum;
  int unsigned period;
  int unsigned len_left;
  logic [2:0]  env_left;
  logic [3:0]  volume;
  logic        sounding;
  logic        dir_held;
  logic [2:0]  per_held;

  sample_t     expected_samples[$];
  int unsigned mismatches;

  function new();
    freq = '0; duty_sel = '0; start_vol = '0; env_up = 1'b0;
    env_per = '0; len_load = '0; len_en = 1'b0;
    duty_step = '0; accum = 0; period = 0; len_left = 0;
    env_left = '0; volume = '0; sounding = 1'b0; dir_held = 1'b0; per_held = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [10:0] data);
    case (idx)
      sqwv_pkg::CfgFrequency:  freq      = data[10:0];
      sqwv_pkg::CfgDutySelect: duty_sel  = data[1:0];
      sqwv_pkg::CfgInitVolume: start_vol = data[3:0];
      sqwv_pkg::CfgEnvUp:      env_up    = data[0];
      sqwv_pkg::CfgEnvPeriod:  env_per   = data[2:0];
      sqwv_pkg::CfgLengthLoad: len_load  = data[5:0];
      sqwv_pkg::CfgLengthEn:   len_en    = data[0];
      default: ;
    endcase
  endfunction

  function int unsigned step_len();
    return 4 * (2048 - int'(freq));
  endfunction

  function int unsigned pending();
    return expected_samples.size();
  endfunction

  function void note_item(sqwv_pkg::func_e op, logic [7:0] cyc);
    sample_t    s;
    logic [7:0] pat;
    case (op)
      sqwv_pkg::FuncTrigger: begin
        duty_step = '0;
        len_left  = sqwv_pkg::LengthFull - len_load;
        period    = step_len();
        accum     = 0;
        volume    = start_vol;
        dir_held  = env_up;
        per_held  = env_per;
        if (per_held != 0) env_left = per_held;
        sounding  = 1'b1;
      end
      sqwv_pkg::FuncAdvance: begin
        accum = accum + cyc;
        if (accum > sqwv_pkg::AccumMax) accum = sqwv_pkg::AccumMax;
        if (accum >= period) begin
          accum     = accum - period;
          period    = step_len();
          duty_step = duty_step + 3'd1;
        end
      end
      sqwv_pkg::FuncLength: begin
        if (len_left > 0) begin
          len_left = len_left - 1;
          if (len_left == 0 && len_en) sounding = 1'b0;
        end
      end
      default: begin
        if (per_held != 0) begin
          env_left = env_left - 3'd1;
          if (env_left == 0) begin
            env_left = per_held;
            if (!dir_held && volume > 0) volume = volume - 4'd1;
            else if (dir_held && volume < sqwv_pkg::VolumeMax) volume = volume + 4'd1;
          end
        end
      end
    endcase
    // Duty patterns, step 0 in the top bit
    case (duty_sel)
      2'd0:    pat = 8'h01;
      2'd1:    pat = 8'h81;
      2'd2:    pat = 8'h87;
      default: pat = 8'h7E;
    endcase
    s.on    = sounding;
    s.level = (sounding && pat[7 - duty_step]) ? volume : 4'd0;
    expected_samples.push_back(s);
  endfunction

  function void check_sample(logic [3:0] level, logic on);
    sample_t s;
    if (expected_samples.size() == 0) begin
      $error("unexpected sample: sample_level %0d channel_on %0b", level, on);
      mismatches++;
    end else begin
      s = expected_samples.pop_front();
      if (level !== s.level) begin
        $error("sample_level: expected %0d, actual %0d", s.level, level);
        mismatches++;
      end
      if (on !== s.on) begin
        $error("channel_on: expected %0b, actual %0b", s.on, on);
        mismatches++;
      end
    end
  endfunction
endclass

module testbench;
  import sqwv_pkg::*;

  localparam int unsigned ItemsTarget = 1000;
  localparam int unsigned CycleLimit  = 300000;
  // Index past the last register: the block must ignore writes to it
  localparam logic [CfgIdxW-1:0]  CfgSpare    = 3'd7;
  localparam logic [CfgDataW-1:0] DataAllOnes = '1;

  typedef enum int unsigned {ReadyAlways, ReadyCoin, ReadyPattern, ReadySparse} ready_mode_e;
  typedef enum int unsigned {StyleMixed, StyleAdvance, StyleTicks} style_e;
  typedef enum int unsigned {SetupLow, SetupHigh, SetupRandom} setup_e;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [FuncW-1:0]    func_i       = '0;
  logic [CyclesW-1:0]  num_cycles_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [LevelW-1:0]   sample_level_o;
  logic                channel_on_o;

  sample_scoreboard board;

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 4;
  bit          gaps_on     = 1'b1;
  ready_mode_e ready_mode  = ReadyAlways;
  int unsigned mode_left   = 0;

  square_wave_sound_channel_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .num_cycles_i   (num_cycles_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_level_o (sample_level_o),
    .channel_on_o   (channel_on_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sample side: hold one stall pattern for a stretch, then switch to another.
  // Always-ready stretches let the block run back to back.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(3));
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left = mode_left - 1;
    end
    case (ready_mode)
      ReadyAlways:  out_ready_i <= 1'b1;
      ReadyCoin:    out_ready_i <= ($urandom_range(1) == 1);
      ReadyPattern: out_ready_i <= (cycle_count % 5 != 2) && (cycle_count % 7 != 4);
      default:      out_ready_i <= ($urandom_range(3) == 0);
    endcase
  end

  // Check every sample taken at a handshake against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_sample(sample_level_o, channel_on_o);
    end
  end

  // Offer one item, idling first when the current burst has run out, and
  // note it for prediction at the edge that accepts it. Valid is left high
  // so that a following item keeps it up without a dip.
  task automatic play(func_e op, logic [CyclesW-1:0] cyc);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) gap = $urandom_range(gap_max);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left = burst_left - 1;
    in_valid_i   <= 1'b1;
    func_i       <= op;
    num_cycles_i <= cyc;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, cyc);
    items_sent++;
  endtask

  // Drop valid and hold off until every owed sample has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // One register write per clock; the caller drops the enable afterwards
  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // Full-width data so that the bits above each register get exercised too
  function automatic logic [CfgDataW-1:0] reg_value(setup_e kind);
    case (kind)
      SetupLow:  return '0;
      SetupHigh: return DataAllOnes;
      default:   return CfgDataW'($urandom_range(2047));
    endcase
  endfunction

  task automatic configure(setup_e kind, bit fast_tone);
    logic [CfgDataW-1:0] tone;
    tone = reg_value(kind);
    // Fast tones step the duty on nearly every advance and let the
    // accumulator climb into saturation
    if (fast_tone && $urandom_range(1) == 1) tone = DataAllOnes;
    set_reg(CfgFrequency, tone);
    set_reg(CfgDutySelect, reg_value(kind));
    set_reg(CfgInitVolume, reg_value(kind));
    set_reg(CfgEnvUp, reg_value(kind));
    set_reg(CfgEnvPeriod, reg_value(kind));
    set_reg(CfgLengthLoad, reg_value(kind));
    set_reg(CfgLengthEn, reg_value(kind));
    if ($urandom_range(2) == 0) set_reg(CfgSpare, reg_value(SetupRandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic func_e pick_op(style_e style);
    int unsigned r;
    int unsigned t_trig;
    int unsigned t_adv;
    int unsigned t_len;
    r = $urandom_range(99);
    case (style)
      StyleAdvance: begin t_trig = 1; t_adv = 91; t_len = 96; end
      StyleTicks:   begin t_trig = 3; t_adv = 28; t_len = 73; end
      default:      begin t_trig = 4; t_adv = 54; t_len = 80; end
    endcase
    if (r < t_trig)     return FuncTrigger;
    else if (r < t_adv) return FuncAdvance;
    else if (r < t_len) return FuncLength;
    else                return FuncEnvelope;
  endfunction

  function automatic logic [CyclesW-1:0] pick_cycles(style_e style);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (style == StyleAdvance) return CyclesW'($urandom_range(128, 255));
    return CyclesW'($urandom_range(255));
  endfunction

  initial begin
    int unsigned phase;
    int unsigned count;
    style_e      style;
    setup_e      kind;

    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Untriggered channel at reset settings: the first advance meets a zero
    // period and steps the duty, a length tick at zero and an envelope tick
    // with no envelope period do nothing
    play(FuncAdvance, '0);
    play(FuncAdvance, '1);
    play(FuncLength, '0);
    play(FuncEnvelope, '1);
    play(FuncTrigger, '0);
    play(FuncAdvance, '1);
    settle();

    // Every register at its top value, plus a write the block must ignore
    set_reg(CfgFrequency, DataAllOnes);
    set_reg(CfgDutySelect, DataAllOnes);
    set_reg(CfgInitVolume, DataAllOnes);
    set_reg(CfgEnvUp, DataAllOnes);
    set_reg(CfgEnvPeriod, DataAllOnes);
    set_reg(CfgLengthLoad, DataAllOnes);
    set_reg(CfgLengthEn, DataAllOnes);
    set_reg(CfgSpare, '0);
    cfg_we_i <= 1'b0;

    // Loudest note at the fastest tone; the envelope pushes against 15, the
    // one-tick length runs out and silences it, a further tick finds zero
    play(FuncTrigger, 8'hA5);
    repeat (3) play(FuncAdvance, '1);
    repeat (7) play(FuncEnvelope, '0);
    play(FuncLength, '0);
    play(FuncLength, '0);
    play(FuncAdvance, '0);
    play(FuncTrigger, '0);
    settle();

    // Falling envelope against zero, and length expiry with the enable off
    set_reg(CfgEnvUp, '0);
    set_reg(CfgEnvPeriod, CfgDataW'(1));
    set_reg(CfgInitVolume, CfgDataW'(1));
    set_reg(CfgLengthEn, '0);
    cfg_we_i <= 1'b0;
    play(FuncTrigger, '0);
    play(FuncEnvelope, '0);
    play(FuncEnvelope, '0);
    play(FuncLength, '0);

    // Random phases: each starts from an idle block with fresh registers,
    // mostly a triggered note followed by a run of items weighted to the
    // phase's style; every fourth phase skips the trigger
    phase = 0;
    while (items_sent < ItemsTarget) begin
      settle();
      style = style_e'(phase % 3);
      kind  = (phase == 0) ? SetupLow : (phase == 1) ? SetupHigh : SetupRandom;
      configure(kind, style == StyleAdvance);
      gaps_on    = ($urandom_range(3) != 0);
      gap_max    = $urandom_range(1, 8);
      burst_left = 0;
      count      = $urandom_range(60, 100);
      if (phase % 4 != 3) begin
        play(FuncTrigger, pick_cycles(style));
        count--;
      end
      repeat (count) play(pick_op(style), pick_cycles(style));
      phase++;
    end

    // Drain, then leave room for anything stray to show up
    settle();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sqwv_pkg.sv
hw/rtl/sqwv_next.sv
hw/rtl/square_wave_sound_channel_core.sv
hw/rtl/sqwv_checker.sv
verif/testbench.sv
